FILE: src/assert_macros.svh
// Assertion macros shared by the blocklist table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/ipmbl_pkg.sv
// Types and constants shared by the blocklist table modules.
`default_nettype none
package ipmbl_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD_IP  = 2'd1,
        OP_ADD_MAC = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        ip_present;
    } t_cmd;

endpackage
`default_nettype wire

FILE: src/ipmbl_front.sv
// Front end: accepts and decodes items into a two-entry command queue.
`default_nettype none
`include "assert_macros.svh"
module ipmbl_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_tvalid,
    output logic                                o_tready,
    input  wire  [ipmbl_pkg::IN_TDATA_W-1:0]    i_tdata,
    output logic                                o_cmd_valid,
    output ipmbl_pkg::t_cmd                     o_cmd,
    input  wire                                 i_cmd_pop
);
    import ipmbl_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    t_cmd       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.op         = t_op'(i_tdata[1:0]);
        in_cmd.ip         = i_tdata[33:2];
        in_cmd.mac        = i_tdata[81:34];
        in_cmd.ip_present = i_tdata[82];
    end

    assign o_tready    = (r_cnt != 2'd2);
    assign push        = i_tvalid && o_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_cmd_pop, r_cnt != 2'd0)
    `ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, push && !i_cmd_pop, r_cnt == $past(r_cnt) + 2'd1)

endmodule
`default_nettype wire

FILE: src/ipmbl_back.sv
// Back end: table memories, append logic, lookup scan and result register.
`default_nettype none
`include "assert_macros.svh"
module ipmbl_back #(
    parameter int IP_DEPTH  = 64,
    parameter int MAC_DEPTH = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_valid,
    input  ipmbl_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output logic             o_hit,
    output logic             o_table_full
);
    import ipmbl_pkg::*;

    localparam int IPCW  = $clog2(IP_DEPTH + 1);
    localparam int MACCW = $clog2(MAC_DEPTH + 1);
    localparam int IPAW  = (IP_DEPTH > 1) ? $clog2(IP_DEPTH) : 1;
    localparam int MACAW = (MAC_DEPTH > 1) ? $clog2(MAC_DEPTH) : 1;
    localparam int SW    = (IPCW > MACCW) ? IPCW : MACCW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    logic [31:0]      r_ip_mem  [IP_DEPTH];
    logic [47:0]      r_mac_mem [MAC_DEPTH];
    logic [31:0]      r_ip_rd;
    logic [47:0]      r_mac_rd;
    logic [IPCW-1:0]  r_ip_count;
    logic [MACCW-1:0] r_mac_count;
    t_state           r_state, n_state;
    logic [SW-1:0]    r_idx;
    logic             r_ipv, r_macv, r_hit, r_ip_on;
    logic [31:0]      r_key_ip;
    logic [47:0]      r_key_mac;
    logic             r_out_valid, r_out_hit, r_out_full;

    logic ip_full, mac_full, out_free, match;
    logic issue_ip, issue_mac, ip_we, mac_we, load;
    logic n_out_hit, n_out_full;

    assign ip_full  = (r_ip_count == IPCW'(IP_DEPTH));
    assign mac_full = (r_mac_count == MACCW'(MAC_DEPTH));
    assign out_free = !r_out_valid || i_out_ready;
    assign match    = (r_ipv && (r_ip_rd == r_key_ip)) || (r_macv && (r_mac_rd == r_key_mac));

    always_comb begin
        issue_ip  = (r_state == S_SCAN) && r_ip_on && (r_idx < SW'(r_ip_count));
        issue_mac = (r_state == S_SCAN) && (r_idx < SW'(r_mac_count));
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        load       = 1'b0;
        n_out_hit  = 1'b0;
        n_out_full = 1'b0;
        ip_we      = 1'b0;
        mac_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            load = 1'b1;
                        end
                        OP_ADD_IP: begin
                            load       = 1'b1;
                            n_out_full = ip_full;
                            ip_we      = !ip_full;
                        end
                        OP_ADD_MAC: begin
                            load       = 1'b1;
                            n_out_full = mac_full;
                            mac_we     = !mac_full;
                        end
                        OP_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!issue_ip && !issue_mac) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read already folded into r_hit during S_SCAN
                if (out_free) begin
                    load      = 1'b1;
                    n_out_hit = r_hit || match;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ip_we) begin
            r_ip_mem[r_ip_count[IPAW-1:0]] <= i_cmd.ip;
        end
        if (issue_ip) begin
            r_ip_rd <= r_ip_mem[r_idx[IPAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_we) begin
            r_mac_mem[r_mac_count[MACAW-1:0]] <= i_cmd.mac;
        end
        if (issue_mac) begin
            r_mac_rd <= r_mac_mem[r_idx[MACAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.op == OP_LOOKUP)) begin
            r_key_ip  <= i_cmd.ip;
            r_key_mac <= i_cmd.mac;
            r_ip_on   <= i_cmd.ip_present;
        end
        if (load) begin
            r_out_hit  <= n_out_hit;
            r_out_full <= n_out_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ip_count  <= '0;
            r_mac_count <= '0;
            r_idx       <= '0;
            r_ipv       <= 1'b0;
            r_macv      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && (i_cmd.op == OP_CLEAR)) begin
                r_ip_count  <= '0;
                r_mac_count <= '0;
            end
            if (ip_we) begin
                r_ip_count <= r_ip_count + IPCW'(1);
            end
            if (mac_we) begin
                r_mac_count <= r_mac_count + MACCW'(1);
            end
            if (o_cmd_pop) begin
                r_idx  <= '0;
                r_ipv  <= 1'b0;
                r_macv <= 1'b0;
                r_hit  <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_idx  <= r_idx + SW'(1);
                r_ipv  <= issue_ip;
                r_macv <= issue_mac;
                r_hit  <= r_hit || match;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_table_full = r_out_full;

    `ASSERT_ALWAYS(a_ip_count_bound, i_clk, i_rst_n, r_ip_count <= IPCW'(IP_DEPTH))
    `ASSERT_ALWAYS(a_mac_count_bound, i_clk, i_rst_n, r_mac_count <= MACCW'(MAC_DEPTH))
    `ASSERT_IMPLIES(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, r_state == S_IDLE)
    `ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, o_cmd_pop && (i_cmd.op == OP_CLEAR), (r_ip_count == '0) && (r_mac_count == '0))

endmodule
`default_nettype wire

FILE: src/ip_mac_blocklist_table_unit.sv
// Top level of the IPv4 / MAC address blocklist table.
//
// Slave stream s_axis carries one command per item: clear both tables, append
// an IP entry, append a MAC entry, or look up an IP/MAC pair. Master stream
// m_axis returns exactly one result item per command (hit, table_full).
// Commands enter a two-entry queue, so the slave side keeps taking items
// while a result waits on a stalled master side; when the queue is full,
// s_axis_tready drops. A stalled result holds on m_axis until taken.
// A lookup scans N entries, where N is the larger of the MAC entry count and
// the IP entry count (the latter only when ip_present is set): the scan reads
// one entry of each table memory per cycle through a single read port each.
// Reset empties both tables by zeroing their counts; entry storage is not
// swept, and no clearing pass is needed after reset.
// Appends to a full table are dropped and answered with table_full set.
`default_nettype none
module ip_mac_blocklist_table_unit #(
    parameter int IP_DEPTH  = 64,
    parameter int MAC_DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] opcode, [33:2] ip_address, [81:34] mac_address, [82] ip_present
    input  wire  [ipmbl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [0] hit, [1] table_full
    output logic [ipmbl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import ipmbl_pkg::*;

    logic cmd_valid, cmd_pop, out_hit, out_full;
    t_cmd cmd;

    ipmbl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ipmbl_back #(
        .IP_DEPTH  (IP_DEPTH),
        .MAC_DEPTH (MAC_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_hit        (out_hit),
        .o_table_full (out_full)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-2){1'b0}}, out_full, out_hit};

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Testbench for the IPv4 / MAC blocklist table: random and directed items against a predictor.
`timescale 1ns / 1ps
module tb;
    import ipmbl_pkg::*;

    localparam int IP_SLOTS    = 64;
    localparam int MAC_SLOTS   = 64;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic hit;
        logic full;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [1:0] opcode, [33:2] ip_address, [81:34] mac_address, [82] ip_present
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] hit, [1] table_full
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predictor state: table copies, fill levels, highest slot ever written
    logic [31:0] ip_table [IP_SLOTS];
    logic [47:0] mac_table [MAC_SLOTS];
    int          ip_used = 0;
    int          mac_used = 0;
    int          ip_high = 0;
    int          mac_high = 0;

    t_verdict    pending_verdicts[$];
    int          failures = 0;
    int          quiet_cycles = 0;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    int          n_cmds = 0;
    int          n_lookups = 0;
    int          n_hits = 0;
    int          n_clears = 0;
    int          n_appends = 0;
    int          n_dropped = 0;

    ip_mac_blocklist_table_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_failure(input string msg);
        if (failures < 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        failures++;
    endtask

    function automatic t_verdict blocklist_predict(input t_cmd c);
        t_verdict v;
        v.hit  = 1'b0;
        v.full = 1'b0;
        case (c.op)
            OP_CLEAR: begin
                ip_used  = 0;
                mac_used = 0;
            end
            OP_ADD_IP: begin
                if (ip_used >= IP_SLOTS) begin
                    v.full = 1'b1;
                end else begin
                    ip_table[ip_used] = c.ip;
                    ip_used++;
                    if (ip_used > ip_high) ip_high = ip_used;
                end
            end
            OP_ADD_MAC: begin
                if (mac_used >= MAC_SLOTS) begin
                    v.full = 1'b1;
                end else begin
                    mac_table[mac_used] = c.mac;
                    mac_used++;
                    if (mac_used > mac_high) mac_high = mac_used;
                end
            end
            default: begin
                for (int k = 0; k < ip_used; k++) begin
                    if (c.ip_present && ip_table[k] == c.ip) v.hit = 1'b1;
                end
                for (int k = 0; k < mac_used; k++) begin
                    if (mac_table[k] == c.mac) v.hit = 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Half live entries, some one-bit neighbors, some stale past a clear, the rest random.
    function automatic logic [31:0] pick_ip();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        v = $urandom;
        if (ip_used > 0 && r < 5) begin
            v = ip_table[$urandom_range(0, ip_used - 1)];
        end else if (ip_used > 0 && r == 5) begin
            v = ip_table[$urandom_range(0, ip_used - 1)] ^ (32'd1 << $urandom_range(0, 31));
        end else if (ip_high > 0 && r == 6) begin
            v = ip_table[$urandom_range(0, ip_high - 1)];
        end
        return v;
    endfunction

    function automatic logic [47:0] pick_mac();
        int          r;
        logic [47:0] v;
        r = $urandom_range(0, 9);
        v = rand_mac();
        if (mac_used > 0 && r < 4) begin
            v = mac_table[$urandom_range(0, mac_used - 1)];
        end else if (mac_used > 0 && r == 4) begin
            v = mac_table[$urandom_range(0, mac_used - 1)] ^ (48'd1 << $urandom_range(0, 47));
        end else if (mac_high > 0 && r == 5) begin
            v = mac_table[$urandom_range(0, mac_high - 1)];
        end
        return v;
    endfunction

    // Call at a rising edge; returns at the edge where the item is taken.
    task automatic send_cmd(input t_op op, input logic [31:0] ip, input logic [47:0] mac,
                            input logic ip_present);
        t_cmd     c;
        t_verdict v;
        c.op         = op;
        c.ip         = ip;
        c.mac        = mac;
        c.ip_present = ip_present;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, c.ip_present, c.mac, c.ip, c.op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        v = blocklist_predict(c);
        pending_verdicts.push_back(v);
        n_cmds++;
        if (op == OP_LOOKUP) n_lookups++;
        if (op == OP_CLEAR) n_clears++;
        if (op == OP_ADD_IP || op == OP_ADD_MAC) n_appends++;
        if (v.hit) n_hits++;
        if (v.full) n_dropped++;
    endtask

    task automatic test_directed();
        send_cmd(OP_LOOKUP, 32'h0, 48'h0, 1'b1);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_cmd(OP_ADD_IP, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_cmd(OP_ADD_IP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        send_cmd(OP_ADD_MAC, 32'hFFFF_FFFF, 48'h0, 1'b1);
        send_cmd(OP_ADD_MAC, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0123, 1'b1);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0123, 1'b0);
        send_cmd(OP_LOOKUP, 32'h0000_0001, 48'h0, 1'b1);
        send_cmd(OP_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b1);
        // duplicates are legal
        send_cmd(OP_ADD_IP, 32'h0, 48'h5, 1'b0);
        send_cmd(OP_LOOKUP, 32'h0, 48'h5, 1'b1);
        send_cmd(OP_CLEAR, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        // old entries stay in storage but must no longer match
        send_cmd(OP_LOOKUP, 32'h0, 48'h0, 1'b1);
        send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_cmd(OP_ADD_MAC, 32'h1234_5678, 48'hA5A5_5A5A_A5A5, 1'b1);
        send_cmd(OP_LOOKUP, 32'h1234_5678, 48'hA5A5_5A5A_A5A5, 1'b0);
        send_cmd(OP_LOOKUP, 32'h1234_5678, 48'hA5A5_5A5A_A5A4, 1'b1);
        send_cmd(OP_ADD_IP, 32'hC0A8_0001, 48'h0, 1'b0);
        send_cmd(OP_LOOKUP, 32'hC0A8_0001, 48'h8000_0000_0000, 1'b1);
        send_cmd(OP_CLEAR, 32'h0, 48'h0, 1'b0);
    endtask

    task automatic test_table_full();
        logic [31:0] ip_last;
        logic [47:0] mac_last;
        for (int k = 0; k < IP_SLOTS; k++) send_cmd(OP_ADD_IP, $urandom, rand_mac(), 1'($urandom));
        ip_last = ip_table[IP_SLOTS - 1];
        send_cmd(OP_ADD_IP, $urandom, rand_mac(), 1'b1);
        send_cmd(OP_ADD_IP, ip_last, rand_mac(), 1'b0);
        send_cmd(OP_LOOKUP, ip_last, rand_mac(), 1'b1);
        send_cmd(OP_LOOKUP, ip_table[0], rand_mac(), 1'b1);
        send_cmd(OP_LOOKUP, ip_last, rand_mac(), 1'b0);
        for (int k = 0; k < MAC_SLOTS; k++) send_cmd(OP_ADD_MAC, $urandom, rand_mac(), 1'($urandom));
        mac_last = mac_table[MAC_SLOTS - 1];
        send_cmd(OP_ADD_MAC, $urandom, rand_mac(), 1'b0);
        send_cmd(OP_ADD_MAC, $urandom, mac_last, 1'b1);
        send_cmd(OP_LOOKUP, $urandom, mac_last, 1'b0);
        send_cmd(OP_LOOKUP, ip_last, mac_table[0], 1'b1);
        send_cmd(OP_CLEAR, $urandom, rand_mac(), 1'($urandom));
        send_cmd(OP_ADD_IP, ip_last, rand_mac(), 1'b0);
        send_cmd(OP_ADD_MAC, $urandom, mac_last, 1'b1);
        send_cmd(OP_LOOKUP, ip_last, mac_last, 1'b1);
    endtask

    task automatic run_random(input int count, input int clear_per_mille, input int append_pct);
        int  r;
        t_op op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 999) < clear_per_mille) op = OP_CLEAR;
            else if (r < append_pct / 2) op = OP_ADD_IP;
            else if (r < append_pct) op = OP_ADD_MAC;
            else op = OP_LOOKUP;
            if (op == OP_LOOKUP) send_cmd(op, pick_ip(), pick_mac(), 1'($urandom));
            else send_cmd(op, $urandom, rand_mac(), 1'($urandom));
        end
    endtask

    // Hold the result side off while the sender keeps going, so the input queue backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_cmd(OP_ADD_IP, $urandom, rand_mac(), 1'b1);
        send_cmd(OP_ADD_MAC, $urandom, rand_mac(), 1'b0);
        run_random(10, 50, 50);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_verdicts.size() == 0) begin
                    flag_failure("result item with nothing expected");
                end else begin
                    if (m_axis_tdata[0] !== pending_verdicts[0].hit) begin
                        flag_failure($sformatf("hit: expected %0b, got %0b",
                                               pending_verdicts[0].hit, m_axis_tdata[0]));
                    end
                    if (m_axis_tdata[1] !== pending_verdicts[0].full) begin
                        flag_failure($sformatf("table_full: expected %0b, got %0b",
                                               pending_verdicts[0].full, m_axis_tdata[1]));
                    end
                    void'(pending_verdicts.pop_front());
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        run_random(350, 8, 50);
        test_backpressure();
        // sparse clears let both tables fill and overflow
        run_random(350, 2, 70);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(300, 10, 40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(300, 5, 50);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(200, 5, 50);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("ran %0d commands: %0d lookups with %0d hits, %0d clears, %0d appends",
                 n_cmds, n_lookups, n_hits, n_clears, n_appends);
        $display("%0d appends dropped on a full table; one %0d-cycle output stall, %0d errors",
                 n_dropped, HOLD_CYCLES, failures);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/ipmbl_pkg.sv
src/ipmbl_front.sv
src/ipmbl_back.sv
src/ip_mac_blocklist_table_unit.sv
verif/tb.sv
